// ===== design/fslbp_pkg.sv =====
// Shared types, widths and micro-op codes for the frame-stamped LRU block pool.
`timescale 1ns / 1ps

package fslbp_pkg;

    // Pool geometry
    localparam int MAX_BLOCKS = 256;
    localparam int FRAME_BITS = 16;
    localparam int SLOT_W     = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = SLOT_W + 1;

    // Beat field widths
    localparam int CMD_W      = 2;
    localparam int BLK_W      = 8;
    localparam int CNT_W      = 9;
    localparam int FRAMEID_W  = 16;
    localparam int STATUS_W   = 2;
    localparam int RESULT_W   = 8;
    localparam int ADDED_W    = 9;

    // Input tdata: block_index, count, frame_id from bit 0 up
    localparam int BLK_LSB    = 0;
    localparam int CNT_LSB    = BLK_LSB + BLK_W;
    localparam int FRM_LSB    = CNT_LSB + CNT_W;
    localparam int S_TDATA_W  = ((FRM_LSB + FRAMEID_W + 7) / 8) * 8;

    // Output tdata: status, result_block, evicted, added_count from bit 0 up
    localparam int M_FIELDS_W = STATUS_W + RESULT_W + 1 + ADDED_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Width wide enough to compare slot numbers, counts and the pool size
    localparam int CMP_W      = (LINK_W > CNT_W) ? LINK_W : CNT_W;

    typedef logic [LINK_W-1:0]     link_t;
    typedef logic [FRAME_BITS-1:0] frame_t;

    localparam link_t NO_SLOT = LINK_W'(MAX_BLOCKS);

    typedef enum logic [CMD_W-1:0] {
        CMD_GET   = 2'd0,
        CMD_USE   = 2'd1,
        CMD_GROUP = 2'd2,
        CMD_ADD   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK   = 2'd0,
        STS_BAD  = 2'd1,
        STS_FULL = 2'd2
    } sts_t;

    // Datapath micro-ops issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_GET_RD,
        OP_GET_EMPTY,
        OP_GET_RECLAIM,
        OP_GET_APPEND,
        OP_FAIL_FULL,
        OP_FAIL_BAD,
        OP_SEL_BLK,
        OP_WALK_RD,
        OP_WALK_STEP,
        OP_STAMP_INIT,
        OP_STAMP,
        OP_STAMP_STEP,
        OP_LOAD,
        OP_LOAD_TAKE,
        OP_FRONT_A,
        OP_FRONT_B,
        OP_FRONT_C,
        OP_ADD_INIT,
        OP_ADD_LINK,
        OP_ADD_SLOT,
        OP_EMIT
    } op_t;

    // Datapath flags seen by the controller
    typedef struct packed {
        cmd_t cmd;
        logic size_zero;
        logic tail_stale;
        logic size_full;
        logic blk_bad;
        logic cnt_zero;
        logic rem_zero;
        logic rem_one;
        logic link_none;
        logic out_free;
    } pool_sts_t;

endpackage

// ===== design/fslbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fslbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/fslbp_datapath.sv =====
// Pool datapath: link, stamp and owner memories, list pointers and result register.
`timescale 1ns / 1ps

module fslbp_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fslbp_pkg::op_t                     op,
    output fslbp_pkg::pool_sts_t               sts,
    input  logic [fslbp_pkg::S_TDATA_W-1:0]    s_tdata,   // block_index, count, frame_id
    input  logic [fslbp_pkg::CMD_W-1:0]        s_tuser,   // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fslbp_pkg::M_TDATA_W-1:0]    m_tdata    // status, result_block, evicted,
                                                          // added_count
);

    import fslbp_pkg::*;

    // Latched command beat
    cmd_t                 cmd_reg, cmd_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    frame_t               frame_reg, frame_next;

    // List state
    link_t                head_reg, head_next;
    link_t                tail_reg, tail_next;
    link_t                size_reg, size_next;

    // Working registers
    link_t                f_reg, f_next;      // front of the moved run
    link_t                e_reg, e_next;      // back of the moved run
    link_t                p_reg, p_next;      // slot before the run
    link_t                nx_reg, nx_next;    // slot after the run
    link_t                w_reg, w_next;      // stamp walk pointer
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic                 fresh_reg, fresh_next;
    logic                 got_reg, got_next;
    sts_t                 sts_reg, sts_next;
    logic                 evict_reg, evict_next;
    logic [ADDED_W-1:0]   added_reg, added_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Memory ports
    logic                 nl_we, pl_we, st_we, ow_we;
    logic [SLOT_W-1:0]    nl_waddr, pl_waddr, st_waddr, ow_waddr;
    logic [SLOT_W-1:0]    nl_raddr, pl_raddr, st_raddr, ow_raddr;
    link_t                nl_wdata, pl_wdata, nl_rdata, pl_rdata;
    frame_t               st_wdata, st_rdata;
    logic                 ow_wdata, ow_rdata;

    logic [CMP_W-1:0]     room;
    logic [CNT_W-1:0]     add_n;
    logic                 relink;
    logic [RESULT_W-1:0]  result;

    fslbp_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BLOCKS)) u_next_ram (
        .aclk(aclk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
        .raddr(nl_raddr), .rdata(nl_rdata)
    );

    fslbp_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BLOCKS)) u_prev_ram (
        .aclk(aclk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
        .raddr(pl_raddr), .rdata(pl_rdata)
    );

    fslbp_ram #(.WIDTH(FRAME_BITS), .DEPTH(MAX_BLOCKS)) u_stamp_ram (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    fslbp_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_owned_ram (
        .aclk(aclk), .we(ow_we), .waddr(ow_waddr), .wdata(ow_wdata),
        .raddr(ow_raddr), .rdata(ow_rdata)
    );

    // Derived values
    assign room   = CMP_W'(MAX_BLOCKS) - CMP_W'(size_reg);
    assign add_n  = (CMP_W'(cnt_reg) < room) ? cnt_reg : CNT_W'(room);
    assign relink = (p_reg != NO_SLOT) || fresh_reg;
    assign result = got_reg ? RESULT_W'(f_reg) : '0;

    // Flags for the controller
    assign sts.cmd        = cmd_reg;
    assign sts.size_zero  = (size_reg == '0);
    assign sts.tail_stale = (st_rdata == '0) || (st_rdata != frame_reg);
    assign sts.size_full  = (size_reg == LINK_W'(MAX_BLOCKS));
    assign sts.blk_bad    = (CMP_W'(blk_reg) >= CMP_W'(size_reg));
    assign sts.cnt_zero   = (cnt_reg == '0);
    assign sts.rem_zero   = (rem_reg == '0);
    assign sts.rem_one    = (rem_reg == CNT_W'(1));
    assign sts.link_none  = (nl_rdata == NO_SLOT);
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Execute the current micro-op
    always_comb begin
        cmd_next     = cmd_reg;
        blk_next     = blk_reg;
        cnt_next     = cnt_reg;
        frame_next   = frame_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        size_next    = size_reg;
        f_next       = f_reg;
        e_next       = e_reg;
        p_next       = p_reg;
        nx_next      = nx_reg;
        w_next       = w_reg;
        rem_next     = rem_reg;
        fresh_next   = fresh_reg;
        got_next     = got_reg;
        sts_next     = sts_reg;
        evict_next   = evict_reg;
        added_next   = added_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        nl_we = 1'b0; nl_waddr = '0; nl_wdata = '0; nl_raddr = '0;
        pl_we = 1'b0; pl_waddr = '0; pl_wdata = '0; pl_raddr = '0;
        st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
        ow_we = 1'b0; ow_waddr = '0; ow_wdata = 1'b0; ow_raddr = '0;

        unique case (op)
            OP_NONE: begin
            end
            OP_LATCH: begin
                cmd_next   = cmd_t'(s_tuser);
                blk_next   = s_tdata[BLK_LSB +: BLK_W];
                cnt_next   = s_tdata[CNT_LSB +: CNT_W];
                frame_next = FRAME_BITS'(s_tdata[FRM_LSB +: FRAMEID_W]);
                sts_next   = STS_OK;
                evict_next = 1'b0;
                added_next = '0;
                got_next   = 1'b0;
                fresh_next = 1'b0;
            end
            OP_GET_RD: begin
                st_raddr = tail_reg[SLOT_W-1:0];
                ow_raddr = tail_reg[SLOT_W-1:0];
            end
            OP_GET_EMPTY: begin
                f_next     = size_reg;
                e_next     = size_reg;
                p_next     = NO_SLOT;
                nx_next    = NO_SLOT;
                fresh_next = 1'b1;
                tail_next  = size_reg;
                size_next  = size_reg + LINK_W'(1);
                got_next   = 1'b1;
            end
            OP_GET_RECLAIM: begin
                f_next     = tail_reg;
                e_next     = tail_reg;
                evict_next = ow_rdata;
                got_next   = 1'b1;
            end
            OP_GET_APPEND: begin
                f_next    = size_reg;
                e_next    = size_reg;
                p_next    = tail_reg;
                nx_next   = NO_SLOT;
                size_next = size_reg + LINK_W'(1);
                got_next  = 1'b1;
            end
            OP_FAIL_FULL: begin
                sts_next = STS_FULL;
            end
            OP_FAIL_BAD: begin
                sts_next = STS_BAD;
            end
            OP_SEL_BLK: begin
                f_next   = LINK_W'(blk_reg);
                e_next   = LINK_W'(blk_reg);
                rem_next = cnt_reg - CNT_W'(1);
            end
            OP_WALK_RD: begin
                nl_raddr = e_reg[SLOT_W-1:0];
            end
            OP_WALK_STEP: begin
                e_next   = nl_rdata;
                rem_next = rem_reg - CNT_W'(1);
            end
            OP_STAMP_INIT: begin
                w_next   = f_reg;
                rem_next = cnt_reg;
            end
            OP_STAMP: begin
                st_we    = 1'b1;
                st_waddr = w_reg[SLOT_W-1:0];
                st_wdata = frame_reg;
                nl_raddr = w_reg[SLOT_W-1:0];
                rem_next = rem_reg - CNT_W'(1);
            end
            OP_STAMP_STEP: begin
                w_next = nl_rdata;
            end
            OP_LOAD: begin
                pl_raddr = f_reg[SLOT_W-1:0];
                nl_raddr = e_reg[SLOT_W-1:0];
            end
            OP_LOAD_TAKE: begin
                p_next  = pl_rdata;
                nx_next = nl_rdata;
            end
            OP_FRONT_A: begin
                // Stamp the slot (not for a group move) and unhook the run from its neighbors
                if (cmd_reg != CMD_GROUP) begin
                    st_we    = 1'b1;
                    st_waddr = f_reg[SLOT_W-1:0];
                    st_wdata = frame_reg;
                end
                if (cmd_reg == CMD_GET) begin
                    ow_we    = 1'b1;
                    ow_waddr = f_reg[SLOT_W-1:0];
                    ow_wdata = 1'b1;
                end
                if (p_reg != NO_SLOT) begin
                    nl_we    = 1'b1;
                    nl_waddr = p_reg[SLOT_W-1:0];
                    nl_wdata = nx_reg;
                    if (nx_reg != NO_SLOT) begin
                        pl_we    = 1'b1;
                        pl_waddr = nx_reg[SLOT_W-1:0];
                        pl_wdata = p_reg;
                    end
                end
            end
            OP_FRONT_B: begin
                // Hook the run in front of the old head
                if (relink) begin
                    nl_we    = 1'b1;
                    nl_waddr = e_reg[SLOT_W-1:0];
                    nl_wdata = head_reg;
                    if (head_reg != NO_SLOT) begin
                        pl_we    = 1'b1;
                        pl_waddr = head_reg[SLOT_W-1:0];
                        pl_wdata = e_reg;
                    end
                end
            end
            OP_FRONT_C: begin
                if (relink) begin
                    pl_we     = 1'b1;
                    pl_waddr  = f_reg[SLOT_W-1:0];
                    pl_wdata  = NO_SLOT;
                    head_next = f_reg;
                end
                if ((p_reg != NO_SLOT) && (nx_reg == NO_SLOT)) begin
                    tail_next = p_reg;
                end
            end
            OP_ADD_INIT: begin
                rem_next   = add_n;
                added_next = ADDED_W'(add_n);
            end
            OP_ADD_LINK: begin
                if (tail_reg != NO_SLOT) begin
                    nl_we    = 1'b1;
                    nl_waddr = tail_reg[SLOT_W-1:0];
                    nl_wdata = size_reg;
                end
            end
            OP_ADD_SLOT: begin
                // Append one slot at the tail, linked forward to the next new one, if any
                pl_we    = 1'b1;
                pl_waddr = size_reg[SLOT_W-1:0];
                pl_wdata = tail_reg;
                nl_we    = 1'b1;
                nl_waddr = size_reg[SLOT_W-1:0];
                nl_wdata = (rem_reg == CNT_W'(1)) ? NO_SLOT : (size_reg + LINK_W'(1));
                st_we    = 1'b1;
                st_waddr = size_reg[SLOT_W-1:0];
                st_wdata = '0;
                ow_we    = 1'b1;
                ow_waddr = size_reg[SLOT_W-1:0];
                ow_wdata = 1'b0;
                tail_next = size_reg;
                if (head_reg == NO_SLOT) begin
                    head_next = size_reg;
                end
                size_next = size_reg + LINK_W'(1);
                rem_next  = rem_reg - CNT_W'(1);
            end
            OP_EMIT: begin
                m_valid_next = 1'b1;
                m_data_next  = M_TDATA_W'({added_reg, evict_reg, result, sts_reg});
            end
            default: begin
            end
        endcase
    end

    // Hold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= NO_SLOT;
            tail_reg    <= NO_SLOT;
            size_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            size_reg    <= size_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg    <= cmd_next;
        blk_reg    <= blk_next;
        cnt_reg    <= cnt_next;
        frame_reg  <= frame_next;
        f_reg      <= f_next;
        e_reg      <= e_next;
        p_reg      <= p_next;
        nx_reg     <= nx_next;
        w_reg      <= w_next;
        rem_reg    <= rem_next;
        fresh_reg  <= fresh_next;
        got_reg    <= got_next;
        sts_reg    <= sts_next;
        evict_reg  <= evict_next;
        added_reg  <= added_next;
        m_data_reg <= m_data_next;
    end

    // Pool never grows past capacity
    a_size_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        size_reg <= LINK_W'(MAX_BLOCKS))
        else $error("pool size beyond capacity");

    // Tail exists exactly when the pool is not empty
    a_tail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (size_reg == '0) == (tail_reg == NO_SLOT))
        else $error("tail and pool size disagree");

    // Tail always lies inside the pool
    a_tail_in_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_reg != NO_SLOT) |-> (tail_reg < size_reg))
        else $error("tail outside pool");

    // A result is loaded only into a free output register
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_EMIT) |-> (!m_valid_reg || m_tready))
        else $error("result overwrites a pending beat");

endmodule

// ===== design/fslbp_ctrl.sv =====
// Pool controller: sequences memory micro-ops for each command beat.
`timescale 1ns / 1ps

module fslbp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  fslbp_pkg::pool_sts_t  sts,
    output fslbp_pkg::op_t        op
);

    import fslbp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_GET_DEC,
        S_LOAD,
        S_LOAD_WAIT,
        S_FRONT_A,
        S_FRONT_B,
        S_FRONT_C,
        S_WALK,
        S_WALK_CHK,
        S_STAMP,
        S_STAMP_CHK,
        S_ADD_CHK,
        S_ADD_SLOT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;

    assign s_tready = s_tready_reg;

    // Next state and micro-op
    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    op         = OP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.cmd)
                    CMD_GET: begin
                        op         = OP_GET_RD;
                        state_next = S_GET_DEC;
                    end
                    CMD_USE: begin
                        if (sts.blk_bad) begin
                            op         = OP_FAIL_BAD;
                            state_next = S_EMIT;
                        end else begin
                            op         = OP_SEL_BLK;
                            state_next = S_LOAD;
                        end
                    end
                    CMD_GROUP: begin
                        priority if (sts.blk_bad) begin
                            op         = OP_FAIL_BAD;
                            state_next = S_EMIT;
                        end else if (sts.cnt_zero) begin
                            state_next = S_EMIT;
                        end else begin
                            op         = OP_SEL_BLK;
                            state_next = S_WALK;
                        end
                    end
                    CMD_ADD: begin
                        op         = OP_ADD_INIT;
                        state_next = S_ADD_CHK;
                    end
                endcase
            end
            S_GET_DEC: begin
                priority if (sts.size_zero) begin
                    op         = OP_GET_EMPTY;
                    state_next = S_FRONT_A;
                end else if (sts.tail_stale) begin
                    op         = OP_GET_RECLAIM;
                    state_next = S_LOAD;
                end else if (!sts.size_full) begin
                    op         = OP_GET_APPEND;
                    state_next = S_FRONT_A;
                end else begin
                    op         = OP_FAIL_FULL;
                    state_next = S_EMIT;
                end
            end
            S_LOAD: begin
                op         = OP_LOAD;
                state_next = S_LOAD_WAIT;
            end
            S_LOAD_WAIT: begin
                op         = OP_LOAD_TAKE;
                state_next = S_FRONT_A;
            end
            S_FRONT_A: begin
                op         = OP_FRONT_A;
                state_next = S_FRONT_B;
            end
            S_FRONT_B: begin
                op         = OP_FRONT_B;
                state_next = S_FRONT_C;
            end
            S_FRONT_C: begin
                op         = OP_FRONT_C;
                state_next = S_EMIT;
            end
            // Check the chain is long enough before touching any stamp
            S_WALK: begin
                if (sts.rem_zero) begin
                    op         = OP_STAMP_INIT;
                    state_next = S_STAMP;
                end else begin
                    op         = OP_WALK_RD;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK: begin
                if (sts.link_none) begin
                    op         = OP_FAIL_BAD;
                    state_next = S_EMIT;
                end else begin
                    op         = OP_WALK_STEP;
                    state_next = S_WALK;
                end
            end
            // Stamp the chain one slot at a time
            S_STAMP: begin
                op         = OP_STAMP;
                state_next = S_STAMP_CHK;
            end
            S_STAMP_CHK: begin
                if (sts.rem_zero) begin
                    state_next = S_LOAD;
                end else begin
                    op         = OP_STAMP_STEP;
                    state_next = S_STAMP;
                end
            end
            S_ADD_CHK: begin
                if (sts.rem_zero) begin
                    state_next = S_EMIT;
                end else begin
                    op         = OP_ADD_LINK;
                    state_next = S_ADD_SLOT;
                end
            end
            S_ADD_SLOT: begin
                op = OP_ADD_SLOT;
                if (sts.rem_one) begin
                    state_next = S_EMIT;
                end
            end
            // Wait for the output register to free up
            S_EMIT: begin
                if (sts.out_free) begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        s_tready_next = (state_next == S_IDLE);
    end

    // Hold state and ready
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

endmodule

// ===== design/frame_stamped_lru_block_pool_unit.sv =====
// Top level of the frame-stamped LRU block pool: controller plus datapath.
`timescale 1ns / 1ps

// The pool keeps its slots in most-recent-first order in linked-list memories and takes one
// command beat at a time: cmd rides in s_tuser, the other fields in s_tdata, and one result
// beat comes back for every command. A get hands out a new slot, reclaims a stale tail, or
// fails when the pool is full and its tail is stamped with the current frame; a use fails
// for a slot outside the pool. A group move walks the chain once to check it and once to
// stamp it, both on the next-link memory port, and ends early for a chain that is too short,
// a zero count or a bad start slot. An add appends one slot at a time, as many as fit. The
// link memories need no clearing after reset; commands are taken right away. A finished
// result waits in an output register, and the next command runs while it waits, stalling
// only when its own result is ready.
module frame_stamped_lru_block_pool_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fslbp_pkg::S_TDATA_W-1:0]    s_tdata,   // block_index, count, frame_id
    input  logic [fslbp_pkg::CMD_W-1:0]        s_tuser,   // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fslbp_pkg::M_TDATA_W-1:0]    m_tdata    // status, result_block, evicted,
                                                          // added_count
);

    import fslbp_pkg::*;

    op_t       op;
    pool_sts_t sts;

    fslbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .op       (op)
    );

    fslbp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
